FILE: src/cle_pkg.sv
// Shared types, character codes and helpers for the console line editor.
`default_nettype none
package cle_pkg;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_WERASE = 8'h17;
    localparam logic [7:0] CH_KILL   = 8'h15;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_char;
        logic [7:0] erase_count;
        logic       line_done;
        logic [7:0] line_length;
        logic [7:0] read_data;
    } cle_result_t;

    // Whitespace for word erase: tab through carriage return, and space.
    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage
`default_nettype wire

FILE: src/cle_line_store.sv
// Line buffer memory: one write port and one registered read port.
`default_nettype none
module cle_line_store
    import cle_pkg::*;
#(
    parameter int LINE_MAX = 128
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [$clog2(LINE_MAX)-1:0] wr_addr,
    input  wire logic [7:0]                  wr_data,
    input  wire logic [$clog2(LINE_MAX)-1:0] rd_addr,
    output logic [7:0]                       rd_data
);

    logic [7:0] mem [LINE_MAX];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

FILE: src/cle_ctrl.sv
// Sequencer for the line editor: decodes a transaction, runs the word-erase
// scan one stored character at a time through a shared count adder.
`default_nettype none
module cle_ctrl
    import cle_pkg::*;
#(
    parameter int LINE_MAX = 128
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic                        cmd,
    input  wire logic [7:0]                  ch,
    input  wire logic [6:0]                  idx,
    input  wire logic [7:0]                  line_limit,
    input  wire logic                        out_free,
    output logic                             idle,
    output logic                             done,
    output cle_result_t                      result,
    output logic                             st_wr_en,
    output logic [$clog2(LINE_MAX)-1:0]      st_wr_addr,
    output logic [7:0]                       st_wr_data,
    output logic [$clog2(LINE_MAX)-1:0]      st_rd_addr,
    input  wire logic [7:0]                  st_rd_data
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int CW = $clog2(LINE_MAX + 1);
    localparam int NW = (CW > 8) ? CW : 8;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EXEC   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_CHECK  = 6'b001000,
        ST_RDWAIT = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           finished_reg, finished_next;
    logic           cmd_reg, cmd_next;
    logic [7:0]     ch_reg, ch_next;
    logic [6:0]     idx_reg, idx_next;
    logic           echo_reg, echo_next;
    logic [7:0]     erase_reg, erase_next;
    logic [7:0]     rdata_reg, rdata_next;

    logic [CW-1:0]  cnt0;
    logic [NW-1:0]  cnt0_ext, lim_raw, lim_max, lim_eff, idx_ext, count_ext;
    logic [CW-1:0]  alu_a, alu_y;
    logic           alu_dec;

    assign cnt0      = finished_reg ? '0 : count_reg;
    assign cnt0_ext  = NW'(cnt0);
    assign count_ext = NW'(count_reg);
    assign idx_ext   = NW'(idx_reg);
    assign lim_raw   = NW'(line_limit);
    assign lim_max   = NW'(LINE_MAX);
    assign lim_eff   = (lim_raw > lim_max) ? lim_max : lim_raw;

    // The single count unit: increments on a store, decrements on an erase.
    assign alu_y = alu_dec ? (alu_a - CW'(1)) : (alu_a + CW'(1));

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        finished_next = finished_reg;
        cmd_next      = cmd_reg;
        ch_next       = ch_reg;
        idx_next      = idx_reg;
        echo_next     = echo_reg;
        erase_next    = erase_reg;
        rdata_next    = rdata_reg;
        alu_a         = count_reg;
        alu_dec       = 1'b1;
        st_wr_en      = 1'b0;
        st_wr_addr    = cnt0[AW-1:0];
        st_wr_data    = ch_reg;
        st_rd_addr    = AW'(idx_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd_next   = cmd;
                    ch_next    = ch;
                    idx_next   = idx;
                    echo_next  = 1'b0;
                    erase_next = 8'd0;
                    rdata_next = 8'd0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                alu_a = cnt0;
                if (cmd_reg == CMD_READ) begin
                    st_rd_addr = AW'(idx_reg);
                    state_next = (idx_ext < count_ext) ? ST_RDWAIT : ST_DONE;
                end else begin
                    finished_next = 1'b0;
                    count_next    = cnt0;
                    state_next    = ST_DONE;
                    if (ch_reg == CH_CR) begin
                        finished_next = 1'b1;
                        if (cnt0_ext < lim_eff) begin
                            alu_dec    = 1'b0;
                            st_wr_en   = 1'b1;
                            st_wr_data = CH_LF;
                            count_next = alu_y;
                        end
                    end else if (cnt0_ext >= lim_eff) begin
                        finished_next = 1'b1;
                    end else if (ch_reg == CH_BS || ch_reg == CH_DEL) begin
                        if (cnt0 != '0) begin
                            count_next = alu_y;
                            erase_next = 8'd1;
                        end
                    end else if (ch_reg == CH_WERASE) begin
                        state_next = ST_SCAN;
                    end else if (ch_reg == CH_KILL) begin
                        erase_next = 8'(cnt0);
                        count_next = '0;
                    end else begin
                        alu_dec    = 1'b0;
                        st_wr_en   = 1'b1;
                        count_next = alu_y;
                        echo_next  = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (count_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    st_rd_addr = alu_y[AW-1:0];
                    count_next = alu_y;
                    erase_next = erase_reg + 8'd1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = is_blank(st_rd_data) ? ST_DONE : ST_SCAN;
            end
            ST_RDWAIT: begin
                rdata_next = st_rd_data;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            finished_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            finished_reg <= finished_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        ch_reg    <= ch_next;
        idx_reg   <= idx_next;
        echo_reg  <= echo_next;
        erase_reg <= erase_next;
        rdata_reg <= rdata_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb begin
        result.echo_valid  = echo_reg;
        result.echo_char   = echo_reg ? ch_reg : 8'd0;
        result.erase_count = erase_reg;
        result.line_done   = finished_reg;
        result.line_length = 8'(count_reg);
        result.read_data   = rdata_reg;
    end

endmodule
`default_nettype wire

FILE: src/console_line_editor_unit.sv
// Top level of the console line editor: stream ports, limit register, result register.
//
//  Channel  | Direction | Payload
//  ---------+-----------+--------------------------------------------------------
//  s_       | in        | tuser: command; tdata: rx_char, read_index
//  m_       | out       | tdata: echo_valid, echo_char, erase_count, line_done,
//           |           |        line_length, read_data
//  cfg_     | in        | wdata: line_limit, written when cfg_we is high
//
// A character or read transaction passes the sequencer states EXEC and DONE (a read
// inside the line also RDWAIT); a word erase loops through SCAN and CHECK, removing
// one stored character per pass with one memory read and one count update, until it
// removes a blank character or the line is empty.
// aresetn is synchronous and clears the line length, the finished flag and the
// limit (to 128); the line memory is not cleared. A stalled m_ side holds the
// result register, and the sequencer waits before taking the next transaction.
`default_nettype none
module console_line_editor_unit
    import cle_pkg::*;
#(
    parameter int LINE_MAX = 128
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] rx_char, [14:8] read_index
    input  wire logic                  s_tuser,   // [0] command
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // [0] echo_valid, [8:1] echo_char,
                                                  // [16:9] erase_count, [17] line_done,
                                                  // [25:18] line_length, [33:26] read_data
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_wdata
);

    localparam int AW = $clog2(LINE_MAX);

    logic [7:0]     limit_reg, limit_next;
    logic           m_tvalid_reg, m_tvalid_next;
    cle_result_t    out_reg, out_next;

    logic           idle, done, out_free;
    cle_result_t    result;
    logic           st_wr_en;
    logic [AW-1:0]  st_wr_addr, st_rd_addr;
    logic [7:0]     st_wr_data, st_rd_data;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = idle;

    cle_ctrl #(
        .LINE_MAX (LINE_MAX)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_tvalid && idle),
        .cmd        (s_tuser),
        .ch         (s_tdata[7:0]),
        .idx        (s_tdata[14:8]),
        .line_limit (limit_reg),
        .out_free   (out_free),
        .idle       (idle),
        .done       (done),
        .result     (result),
        .st_wr_en   (st_wr_en),
        .st_wr_addr (st_wr_addr),
        .st_wr_data (st_wr_data),
        .st_rd_addr (st_rd_addr),
        .st_rd_data (st_rd_data)
    );

    cle_line_store #(
        .LINE_MAX (LINE_MAX)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    always_comb begin
        limit_next    = cfg_we ? cfg_wdata : limit_reg;
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (done && out_free) begin
            m_tvalid_next = 1'b1;
            out_next      = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= 8'd128;
            m_tvalid_reg <= 1'b0;
        end else begin
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_reg.read_data, out_reg.line_length, out_reg.line_done,
                       out_reg.erase_count, out_reg.echo_char, out_reg.echo_valid};

endmodule
`default_nettype wire
